// ----- hw/rtl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared codes, types and helpers for the Playfair digraph encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int LETTER_W = 5;
    localparam int CMD_W    = 2;

    // Command codes carried on the input side-band.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd3;

    localparam logic [LETTER_W-1:0] LETTER_I    = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J    = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_MAX  = 5'd25;
    localparam logic [LETTER_W-1:0] PAD_RESET   = 5'd23;
    localparam int                  ALPHA_SIZE  = 26;
    localparam int                  SQUARE_SIZE = 25;
    localparam logic [2:0]          SIDE_LAST   = 3'd4;
    localparam logic [2:0]          SIDE_END    = 3'd5;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;
        logic clear;
        logic place_key;
        logic fill_start;
        logic fill_step;
        logic set_pending;
        logic clr_pending;
        logic set_held;
        logic clr_held;
        logic pos_rd_a;
        logic pos_rd_b;
        logic b_is_pad;
        logic sq_rd_a;
        logic sq_rd_b;
        logic cap_second;
        logic out_first;
        logic out_second;
    } pfe_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             letter_ok;
        logic             square_done;
        logic             pending_valid;
        logic             held_valid;
        logic             letter_eq_pending;
        logic             fill_end;
        logic             out_free;
    } pfe_status_t;

    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

endpackage

// ----- hw/rtl/pfe_dp.sv -----
// ----------------------------------------------------------------------------
// pfe_dp
// Datapath: key square and letter position memories, fill walker, pending
// and held state, pair encoder and the output register.
// ----------------------------------------------------------------------------
module pfe_dp
    import pfe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [LETTER_W-1:0] cfg_wdata,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [LETTER_W-1:0] in_letter,
    input  pfe_cmd_t            ctl,
    output pfe_status_t         status,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [LETTER_W-1:0] m_letter,
    output logic                m_last
);

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pos_t;

    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [LETTER_W-1:0] lin_addr(input logic [2:0] row,
                                                     input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // Cipher position of the letter at "own" given its partner at "other".
    function automatic logic [LETTER_W-1:0] sq_addr(input pos_t own, input pos_t other);
        logic [LETTER_W-1:0] a;
        if (own.row == other.row) begin
            a = lin_addr(own.row, inc5(own.col));
        end else if (own.col == other.col) begin
            a = lin_addr(inc5(own.row), own.col);
        end else begin
            a = lin_addr(own.row, other.col);
        end
        return a;
    endfunction

    logic [LETTER_W-1:0] square_mem [SQUARE_SIZE];
    pos_t                pos_mem    [ALPHA_SIZE];

    logic [CMD_W-1:0]    cmd_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                letter_ok_reg;
    logic [LETTER_W-1:0] pad_reg, pad_next;
    logic [ALPHA_SIZE-1:0] used_reg, used_next;
    logic [2:0]          fill_row_reg, fill_row_next;
    logic [2:0]          fill_col_reg, fill_col_next;
    logic [LETTER_W-1:0] fill_cnt_reg;
    logic                done_reg, done_next;
    logic [LETTER_W-1:0] pending_reg;
    logic                pending_valid_reg, pending_valid_next;
    logic                held_valid_reg, held_valid_next;
    pos_t                pos_rd_reg, pa_reg, pb_reg;
    logic [LETTER_W-1:0] sq_rd_reg;
    logic [LETTER_W-1:0] first_reg, second_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [LETTER_W-1:0] m_letter_reg;
    logic                m_last_reg;

    logic [LETTER_W-1:0] pad_code;
    logic [LETTER_W-1:0] place_letter;
    logic                place_go;
    logic [LETTER_W-1:0] pos_addr;
    logic [LETTER_W-1:0] sq_rd_addr;
    logic                out_free;

    assign pad_code     = fold_letter((pad_reg > LETTER_MAX) ? PAD_RESET : pad_reg);
    assign place_letter = ctl.place_key ? letter_reg : fill_cnt_reg;
    assign place_go     = (ctl.place_key || (ctl.fill_step && fill_cnt_reg != LETTER_J))
                          && !used_reg[place_letter] && (fill_row_reg != SIDE_END);
    assign pos_addr     = ctl.pos_rd_a ? pending_reg : (ctl.b_is_pad ? pad_code : letter_reg);
    assign sq_rd_addr   = ctl.sq_rd_a ? sq_addr(pa_reg, pos_rd_reg) : sq_addr(pb_reg, pa_reg);
    assign out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        pad_next           = cfg_we ? cfg_wdata : pad_reg;
        used_next          = used_reg;
        fill_row_next      = fill_row_reg;
        fill_col_next      = fill_col_reg;
        done_next          = done_reg;
        pending_valid_next = pending_valid_reg;
        held_valid_next    = held_valid_reg;
        if (place_go) begin
            used_next[place_letter] = 1'b1;
            if (fill_col_reg == SIDE_LAST) begin
                fill_col_next = 3'd0;
                fill_row_next = fill_row_reg + 3'd1;
            end else begin
                fill_col_next = fill_col_reg + 3'd1;
            end
        end
        if (ctl.fill_step && fill_cnt_reg == LETTER_MAX) begin
            done_next = 1'b1;
        end
        if (ctl.set_pending) begin
            pending_valid_next = 1'b1;
        end
        if (ctl.clr_pending) begin
            pending_valid_next = 1'b0;
        end
        if (ctl.set_held) begin
            held_valid_next = 1'b1;
        end
        if (ctl.clr_held) begin
            held_valid_next = 1'b0;
        end
        if (ctl.clear) begin
            used_next          = '0;
            fill_row_next      = 3'd0;
            fill_col_next      = 3'd0;
            done_next          = 1'b0;
            pending_valid_next = 1'b0;
            held_valid_next    = 1'b0;
        end
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        if (ctl.out_first || ctl.out_second) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_reg           <= PAD_RESET;
            used_reg          <= '0;
            fill_row_reg      <= 3'd0;
            fill_col_reg      <= 3'd0;
            done_reg          <= 1'b0;
            pending_valid_reg <= 1'b0;
            held_valid_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            pad_reg           <= pad_next;
            used_reg          <= used_next;
            fill_row_reg      <= fill_row_next;
            fill_col_reg      <= fill_col_next;
            done_reg          <= done_next;
            pending_valid_reg <= pending_valid_next;
            held_valid_reg    <= held_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            cmd_reg       <= in_cmd;
            letter_reg    <= fold_letter(in_letter);
            letter_ok_reg <= (in_letter <= LETTER_MAX);
        end
        if (ctl.fill_start) begin
            fill_cnt_reg <= '0;
        end else if (ctl.fill_step) begin
            fill_cnt_reg <= fill_cnt_reg + 5'd1;
        end
        if (ctl.set_pending) begin
            pending_reg <= letter_reg;
        end
        if (ctl.pos_rd_b) begin
            pa_reg <= pos_rd_reg;
        end
        if (ctl.sq_rd_a) begin
            pb_reg <= pos_rd_reg;
        end
        if (ctl.sq_rd_b) begin
            first_reg <= sq_rd_reg;
        end
        if (ctl.cap_second) begin
            second_reg <= sq_rd_reg;
        end
        if (ctl.out_first) begin
            m_letter_reg <= first_reg;
            m_last_reg   <= 1'b0;
        end else if (ctl.out_second) begin
            m_letter_reg <= second_reg;
            m_last_reg   <= (cmd_reg == CMD_END);
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (place_go) begin
            square_mem[lin_addr(fill_row_reg, fill_col_reg)] <= place_letter;
            pos_mem[place_letter] <= '{row: fill_row_reg, col: fill_col_reg};
        end
        if (ctl.pos_rd_a || ctl.pos_rd_b) begin
            pos_rd_reg <= pos_mem[pos_addr];
        end
        if (ctl.sq_rd_a || ctl.sq_rd_b) begin
            sq_rd_reg <= square_mem[sq_rd_addr];
        end
    end

    assign status.cmd               = cmd_reg;
    assign status.letter_ok         = letter_ok_reg;
    assign status.square_done       = done_reg;
    assign status.pending_valid     = pending_valid_reg;
    assign status.held_valid        = held_valid_reg;
    assign status.letter_eq_pending = (letter_reg == pending_reg);
    assign status.fill_end          = (fill_cnt_reg == LETTER_MAX);
    assign status.out_free          = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_letter = m_letter_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- hw/rtl/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// Controller: sequences one request at a time through key placement,
// alphabet fill, pair encoding and the two output letters.
// ----------------------------------------------------------------------------
module pfe_ctrl
    import pfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  pfe_status_t status,
    output pfe_cmd_t    ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_FILL,
        S_TEXT,
        S_POS_A,
        S_POS_B,
        S_SQ_A,
        S_SQ_B,
        S_SQ_DONE,
        S_EMIT1,
        S_EMIT2
    } state_t;

    state_t state_reg, state_next;
    logic   is_end;
    logic   pad_pair;

    assign is_end   = (status.cmd == CMD_END);
    // The second letter is the pad at message end and for a doubled letter.
    assign pad_pair = is_end || status.letter_eq_pending;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_IDLE;
                case (status.cmd)
                    CMD_CLEAR: begin
                        ctl.clear = 1'b1;
                    end
                    CMD_KEY: begin
                        ctl.place_key = status.letter_ok && !status.square_done;
                    end
                    CMD_TEXT: begin
                        if (status.letter_ok) begin
                            if (status.square_done) begin
                                state_next = S_TEXT;
                            end else begin
                                ctl.fill_start = 1'b1;
                                state_next     = S_FILL;
                            end
                        end
                    end
                    default: begin
                        if (status.held_valid) begin
                            ctl.clr_held    = 1'b1;
                            ctl.clr_pending = 1'b1;
                            state_next      = S_EMIT1;
                        end else if (status.pending_valid) begin
                            if (status.square_done) begin
                                state_next = S_POS_A;
                            end else begin
                                ctl.fill_start = 1'b1;
                                state_next     = S_FILL;
                            end
                        end
                    end
                endcase
            end
            S_FILL: begin
                ctl.fill_step = 1'b1;
                if (status.fill_end) begin
                    state_next = is_end ? S_POS_A : S_TEXT;
                end
            end
            S_TEXT: begin
                if (!status.pending_valid) begin
                    ctl.set_pending = 1'b1;
                    if (status.held_valid) begin
                        ctl.clr_held = 1'b1;
                        state_next   = S_EMIT1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_POS_A;
                end
            end
            S_POS_A: begin
                ctl.pos_rd_a = 1'b1;
                state_next   = S_POS_B;
            end
            S_POS_B: begin
                ctl.pos_rd_b = 1'b1;
                ctl.b_is_pad = pad_pair;
                state_next   = S_SQ_A;
            end
            S_SQ_A: begin
                ctl.sq_rd_a = 1'b1;
                state_next  = S_SQ_B;
            end
            S_SQ_B: begin
                ctl.sq_rd_b = 1'b1;
                state_next  = S_SQ_DONE;
            end
            S_SQ_DONE: begin
                ctl.cap_second = 1'b1;
                if (is_end) begin
                    ctl.clr_pending = 1'b1;
                    state_next      = S_EMIT1;
                end else if (status.letter_eq_pending) begin
                    state_next = S_EMIT1;
                end else begin
                    // A completed pair waits until the next text letter or the end.
                    ctl.set_held    = 1'b1;
                    ctl.clr_pending = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT1: begin
                if (status.out_free) begin
                    ctl.out_first = 1'b1;
                    state_next    = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (status.out_free) begin
                    ctl.out_second = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/playfair_digraph_encrypt.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt
// Playfair encryptor over letter codes a=0 to z=25 with a 5x5 key square.
// ----------------------------------------------------------------------------
// One request is handled at a time. A clear, a key letter, an ignored letter
// or an end with nothing left is finished in the decide state. A text letter
// may only become the pending letter, or may also release a held pair, which
// then waits on output stalls. A text letter that completes a pair is encoded
// and the pair is held; a doubled letter is encoded with the pad and sent,
// subject to output stalls. The pair encoder reads the position memory twice
// and the square memory twice through single read ports. An end of message
// sends a held pair, or encodes a pending letter with the pad and sends it,
// subject to output stalls. The first text letter after a clear also walks
// the alphabet once to complete the square. The output register lets the
// next request be accepted while the last letter waits.
module playfair_digraph_encrypt
    import pfe_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [LETTER_W-1:0] cfg_wdata,     // pad_letter
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,       // [4:0] letter
    input  logic [CMD_W-1:0]    s_tuser,       // [1:0] cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,       // [4:0] cipher_letter
    output logic                m_tlast
);

    pfe_cmd_t            ctl;
    pfe_status_t         status;
    logic [LETTER_W-1:0] m_letter;

    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctl      (ctl)
    );

    pfe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_letter (s_tdata[LETTER_W-1:0]),
        .ctl       (ctl),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_letter  (m_letter),
        .m_last    (m_tlast)
    );

    assign m_tdata = {3'b000, m_letter};

endmodule
